FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define XSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define XSW_ASSERT_NEVER(lbl, expr, msg) \
  `XSW_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/xsw_pkg.sv
// ----------------------------------------------------------------------------
// xsw_pkg
// Types and constants of the 128-bit xorshift1024* generator.
// ----------------------------------------------------------------------------
package xsw_pkg;

  localparam logic [63:0] MultLow = 64'h106689D45497FDB5;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned TableAw = $clog2(TableDepth);

  localparam int unsigned MixShiftA = 31;
  localparam int unsigned MixShiftB = 11;
  localparam int unsigned MixShiftC = 30;

  localparam int unsigned SeedShiftA = 23;
  localparam int unsigned SeedShiftB = 17;
  localparam int unsigned SeedShiftC = 26;

  localparam int unsigned MulSteps = 4;
  localparam int unsigned MulCntW = $clog2(MulSteps + 1);

  localparam int unsigned JobQueueDepth = 2;
  localparam int unsigned ResQueueDepth = 2;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    JOB_DRAW,
    JOB_SEED,
    JOB_REJECT
  } job_e;

  typedef struct packed {
    job_e        kind;
    logic [63:0] seed_a;
    logic [63:0] seed_b;
  } job_t;

  typedef struct packed {
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic        seed_rejected;
  } result_t;

endpackage

FILE: rtl/xsw_fifo.sv
// ----------------------------------------------------------------------------
// xsw_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module xsw_fifo #(
  parameter type item_t = logic,
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t item_o,
  output logic  empty_o
);

  localparam int unsigned Aw = $clog2(Depth);
  localparam int unsigned Cw = $clog2(Depth + 1);

  item_t          mem_q [Depth];
  logic  [Aw-1:0] wr_q;
  logic  [Aw-1:0] rd_q;
  logic  [Cw-1:0] cnt_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == Cw'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Cw'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Cw'(1);
      end
    end
  end

endmodule

FILE: rtl/xsw_front.sv
// ----------------------------------------------------------------------------
// xsw_front
// Accepts commands, sorts them into draw, seed and rejected seed jobs, and
// queues them for the execution side.
// ----------------------------------------------------------------------------
module xsw_front #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          command_i,
  input  logic [63:0]   seed_first_i,
  input  logic [63:0]   seed_second_i,
  output logic          full_o,
  output logic          job_valid_o,
  input  logic          job_pop_i,
  output xsw_pkg::job_t job_o
);

  import xsw_pkg::*;

  job_t job_in;
  logic job_empty;

  always_comb begin
    job_in.seed_a = seed_first_i;
    job_in.seed_b = seed_second_i;
    if (command_i == CMD_SEED) begin
      job_in.kind = ((seed_first_i | seed_second_i) == '0) ? JOB_REJECT : JOB_SEED;
    end else begin
      job_in.kind = JOB_DRAW;
    end
  end

  xsw_fifo #(
    .item_t(job_t),
    .Depth (Depth)
  ) u_job_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .item_i (job_in),
    .full_o (full_o),
    .pop_i  (job_pop_i),
    .item_o (job_o),
    .empty_o(job_empty)
  );

  assign job_valid_o = !job_empty;

endmodule

FILE: rtl/xsw_back.sv
// ----------------------------------------------------------------------------
// xsw_back
// Executes jobs: table update and iterative wide multiply for draws, and the
// stepped seeder with warm-up and table fill for seeds, and a zero result for rejected seeds.
// ----------------------------------------------------------------------------
module xsw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  xsw_pkg::job_t    job_i,
  output logic             job_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output xsw_pkg::result_t res_o
);

  import xsw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_MUL,
    ST_WARM,
    ST_FILL,
    ST_RESULT
  } state_e;

  state_e                state_q;
  logic [TableAw-1:0]    ptr_q;
  logic [TableAw-1:0]    ptr_nxt;
  logic [TableDepth-1:0] valid_q;
  logic [63:0]           mem_q [TableDepth];
  logic [63:0]           rd0_q;
  logic [63:0]           rd1_q;
  logic                  rdv0_q;
  logic                  rdv1_q;
  logic [63:0]           sa_q;
  logic [63:0]           sb_q;
  logic [1:0]            wk_q;
  logic                  second_q;
  logic [TableAw-1:0]    fill_q;
  logic [63:0]           w_q;
  logic [127:0]          acc_q;
  logic [63:0]           prod_q;
  logic [MulCntW-1:0]    mcnt_q;
  logic                  rej_q;

  logic [63:0]           s0;
  logic [63:0]           s1;
  logic [63:0]           s0x;
  logic [63:0]           s1x;
  logic [63:0]           s1y;
  logic [63:0]           mix_w;
  logic [63:0]           sx;
  logic [63:0]           sx2;
  logic [63:0]           sy;
  logic [63:0]           seed_b_nxt;
  logic [63:0]           seed_out;
  logic                  mem_we;
  logic [TableAw-1:0]    mem_waddr;
  logic [63:0]           mem_wdata;
  logic [31:0]           mul_a;
  logic [31:0]           mul_b;
  logic [63:0]           mul_prod;
  logic [127:0]          acc_add;

  assign ptr_nxt = ptr_q + TableAw'(1);

  assign s0    = rdv0_q ? rd0_q : '0;
  assign s1    = rdv1_q ? rd1_q : '0;
  assign s1x   = s1 ^ (s1 << MixShiftA);
  assign s1y   = s1x ^ (s1x >> MixShiftB);
  assign s0x   = s0 ^ (s0 >> MixShiftC);
  assign mix_w = s0x ^ s1y;

  assign sx         = sa_q ^ (sa_q << SeedShiftA);
  assign sx2        = sx ^ (sx >> SeedShiftB);
  assign sy         = sb_q ^ (sb_q >> SeedShiftC);
  assign seed_b_nxt = sx2 ^ sy;
  assign seed_out   = seed_b_nxt + sb_q;

  assign mem_we    = (state_q == ST_MIX) || (state_q == ST_FILL);
  assign mem_waddr = (state_q == ST_MIX) ? ptr_nxt : fill_q;
  assign mem_wdata = (state_q == ST_MIX) ? mix_w : seed_out;

  assign mul_a    = mcnt_q[1] ? w_q[63:32] : w_q[31:0];
  assign mul_b    = mcnt_q[0] ? MultLow[63:32] : MultLow[31:0];
  assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    case (mcnt_q) inside
      MulCntW'(1):              acc_add = {64'd0, prod_q};
      MulCntW'(2), MulCntW'(3): acc_add = {32'd0, prod_q, 32'd0};
      MulCntW'(4):              acc_add = {prod_q, 64'd0};
      default:                  acc_add = '0;
    endcase
  end

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign res_push_o = (state_q == ST_RESULT) && !res_full_i;
  assign res_o      = '{value_high: acc_q[127:64], value_low: acc_q[63:0],
                        seed_rejected: rej_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd0_q <= mem_q[ptr_q];
    rd1_q <= mem_q[ptr_nxt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdv0_q <= 1'b0;
      rdv1_q <= 1'b0;
    end else begin
      rdv0_q <= valid_q[ptr_q];
      rdv1_q <= valid_q[ptr_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= '0;
      valid_q  <= '0;
      sa_q     <= '0;
      sb_q     <= '0;
      wk_q     <= '0;
      second_q <= 1'b0;
      fill_q   <= '0;
      w_q      <= '0;
      acc_q    <= '0;
      prod_q   <= '0;
      mcnt_q   <= '0;
      rej_q    <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            unique case (job_i.kind)
              JOB_DRAW: begin
                state_q <= ST_MIX;
              end
              JOB_SEED: begin
                sa_q     <= job_i.seed_a;
                sb_q     <= job_i.seed_b;
                wk_q     <= '0;
                second_q <= 1'b0;
                acc_q    <= '0;
                rej_q    <= 1'b0;
                state_q  <= ST_WARM;
              end
              JOB_REJECT: begin
                acc_q   <= '0;
                rej_q   <= 1'b1;
                state_q <= ST_RESULT;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MIX: begin
          ptr_q   <= ptr_nxt;
          w_q     <= mix_w;
          acc_q   <= {mix_w + MultLow, 64'd0};
          rej_q   <= 1'b0;
          mcnt_q  <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q <= mul_prod;
          acc_q  <= acc_q + acc_add;
          if (mcnt_q == MulCntW'(MulSteps)) begin
            state_q <= ST_RESULT;
          end else begin
            mcnt_q <= mcnt_q + MulCntW'(1);
          end
        end
        ST_WARM: begin
          sa_q <= sb_q;
          sb_q <= seed_b_nxt;
          if (seed_out[1:0] == wk_q) begin
            wk_q <= wk_q + 2'd1;
            if (wk_q == 2'd3) begin
              if (second_q) begin
                state_q <= ST_RESULT;
              end else begin
                fill_q  <= '0;
                state_q <= ST_FILL;
              end
            end
          end
        end
        ST_FILL: begin
          sa_q   <= sb_q;
          sb_q   <= seed_b_nxt;
          fill_q <= fill_q + TableAw'(1);
          if (fill_q == TableAw'(TableDepth - 1)) begin
            second_q <= 1'b1;
            state_q  <= ST_WARM;
          end
        end
        ST_RESULT: begin
          if (!res_full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/xorshift1024_star_wide_generator.sv
// ----------------------------------------------------------------------------
// xorshift1024_star_wide_generator
// 128-bit xorshift1024* generator with a 16-word table, seeded from an
// xorshift128+ seeder.
//
// Channel   Direction  Handshake     Fields
// command   in         push / full   command_i, seed_first_i, seed_second_i
// result    out        pop / empty   value_high_o, value_low_o, seed_rejected_o
//
// A command is registered in the job queue before execution starts.
// A draw passes through the execution unit as table read, mix and write,
// then five steps of the shared 32x32 multiplier with accumulation.
// A seed runs a warm-up, a fill of the whole table and a second warm-up,
// stepping the seeder once per cycle; a rejected seed goes straight to the result.
// Reset clears the table valid flags at once, so no clearing pass is needed.
// The job queue and result queue let either side stall without stopping the other.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xorshift1024_star_wide_generator #(
  parameter int unsigned JobDepth = xsw_pkg::JobQueueDepth,
  parameter int unsigned ResDepth = xsw_pkg::ResQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [63:0] seed_first_i,
  input  logic [63:0] seed_second_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value_high_o,
  output logic [63:0] value_low_o,
  output logic        seed_rejected_o
);

  import xsw_pkg::*;

  job_t    job;
  logic    job_valid;
  logic    job_pop;
  result_t res;
  logic    res_push;
  logic    res_full;
  result_t res_head;

  xsw_front #(
    .Depth(JobDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .command_i    (command_i),
    .seed_first_i (seed_first_i),
    .seed_second_i(seed_second_i),
    .full_o       (full),
    .job_valid_o  (job_valid),
    .job_pop_i    (job_pop),
    .job_o        (job)
  );

  xsw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job),
    .job_pop_o  (job_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  xsw_fifo #(
    .item_t(result_t),
    .Depth (ResDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .item_i (res),
    .full_o (res_full),
    .pop_i  (pop),
    .item_o (res_head),
    .empty_o(empty)
  );

  assign value_high_o    = res_head.value_high;
  assign value_low_o     = res_head.value_low;
  assign seed_rejected_o = res_head.seed_rejected;

  `XSW_ASSERT(a_job_pop_valid, job_pop |-> job_valid, "Job taken from an empty queue.")
  `XSW_ASSERT_NEVER(a_res_push_full, res_push && res_full, "Result pushed into a full queue.")
  `XSW_ASSERT(a_reject_zero, (res_push && res.seed_rejected) |-> ((res.value_high == '0) && (res.value_low == '0)), "Rejected seed with nonzero value.")

endmodule

FILE: tb/xsw_stream_checker.sv
// ----------------------------------------------------------------------------
// xsw_stream_checker
// Watches the command and result channels of the 128-bit xorshift1024*
// generator, predicts every result from its own copy of the table, pointer
// and seeder, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module xsw_stream_checker
  import xsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        command_i,
  input  logic [63:0] seed_first_i,
  input  logic [63:0] seed_second_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] value_high_o,
  input  logic [63:0] value_low_o,
  input  logic        seed_rejected_o,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0]        mix_words [TableDepth] = '{default: '0};
  logic [TableAw-1:0] mix_ptr = '0;
  logic [63:0]        seeder_a = '0;
  logic [63:0]        seeder_b = '0;
  result_t            expected_values [$];
  int                 mismatch_count = 0;

  function automatic logic [63:0] seeder_step();
    logic [63:0] x;
    logic [63:0] y;
    x = seeder_a;
    y = seeder_b;
    seeder_a = y;
    x = x ^ (x << SeedShiftA);
    x = x ^ (x >> SeedShiftB);
    y = y ^ (y >> SeedShiftC);
    seeder_b = x ^ y;
    return seeder_b + seeder_a;
  endfunction

  function automatic void warm_seeder();
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      v = seeder_step();
      while (v[1:0] != k[1:0]) v = seeder_step();
    end
  endfunction

  function automatic result_t next_result(input cmd_e cmd, input logic [63:0] first,
                                          input logic [63:0] second);
    result_t      r;
    logic [63:0]  s0;
    logic [63:0]  s1;
    logic [63:0]  w;
    logic [127:0] prod;
    r = '0;
    if (cmd == CMD_SEED) begin
      if (first == '0 && second == '0) begin
        r.seed_rejected = 1'b1;
      end else begin
        seeder_a = first;
        seeder_b = second;
        warm_seeder();
        for (int i = 0; i < TableDepth; i++) mix_words[i] = seeder_step();
        warm_seeder();
      end
    end else begin
      s0 = mix_words[mix_ptr];
      mix_ptr = mix_ptr + 1'b1;
      s1 = mix_words[mix_ptr];
      s1 = s1 ^ (s1 << MixShiftA);
      s1 = s1 ^ (s1 >> MixShiftB);
      s0 = s0 ^ (s0 >> MixShiftC);
      w = s0 ^ s1;
      mix_words[mix_ptr] = w;
      prod = {64'd1, w} * {64'd1, MultLow};
      r.value_high = prod[127:64];
      r.value_low  = prod[63:0];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (push && !full) begin
        expected_values.push_back(next_result(cmd_e'(command_i), seed_first_i, seed_second_i));
      end
      if (pop && !empty) begin
        if (expected_values.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: unexpected result high=%h low=%h rejected=%b", $realtime,
                     value_high_o, value_low_o, seed_rejected_o);
          end
        end else begin
          want = expected_values.pop_front();
          if (want.value_high !== value_high_o || want.value_low !== value_low_o ||
              want.seed_rejected !== seed_rejected_o) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch expected high=%h low=%h rejected=%b", $realtime,
                       want.value_high, want.value_low, want.seed_rejected);
              $display("%0t:                   actual high=%h low=%h rejected=%b", $realtime,
                       value_high_o, value_low_o, seed_rejected_o);
            end
          end
        end
      end
    end
    fail_count_o <= mismatch_count;
    pending_o    <= expected_values.size();
  end

endmodule

FILE: tb/xorshift1024_star_wide_generator_tb.sv
// ----------------------------------------------------------------------------
// xorshift1024_star_wide_generator_tb
// Drives draw and seed commands into the generator in random bursts, with
// directed cases first (draws on the unseeded table, rejected all-zero
// seeds, extreme seed words), while the result side stalls on its own
// pattern. A separate checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module xorshift1024_star_wide_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xsw_pkg::*;

  localparam int IdleLimit   = 20000;
  localparam int RandomItems = 400;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        full;
  logic        command_i     = CMD_DRAW;
  logic [63:0] seed_first_i  = '0;
  logic [63:0] seed_second_i = '0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [63:0] value_high_o;
  logic [63:0] value_low_o;
  logic        seed_rejected_o;

  int fail_count;
  int pending;
  int burst_left  = 0;
  int idle_cycles = 0;
  int pop_mode    = 0;
  int pop_left    = 0;

  always #1 clk_i = ~clk_i;

  xorshift1024_star_wide_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .seed_first_i   (seed_first_i),
    .seed_second_i  (seed_second_i),
    .empty          (empty),
    .pop            (pop),
    .value_high_o   (value_high_o),
    .value_low_o    (value_low_o),
    .seed_rejected_o(seed_rejected_o)
  );

  xsw_stream_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .seed_first_i   (seed_first_i),
    .seed_second_i  (seed_second_i),
    .empty          (empty),
    .pop            (pop),
    .value_high_o   (value_high_o),
    .value_low_o    (value_low_o),
    .seed_rejected_o(seed_rejected_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_left == 0) begin
        pop_mode <= $urandom_range(2, 0);
        pop_left <= $urandom_range(40, 1);
      end else begin
        pop_left <= pop_left - 1;
      end
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(1, 0));
        default: pop <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("xorshift1024_star_wide_generator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] pick_word();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63, 0);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [63:0] first,
                           input logic [63:0] second);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    command_i     <= cmd;
    seed_first_i  <= first;
    seed_second_i <= second;
    push          <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_DRAW, '0, '0);
    send_item(CMD_DRAW, '1, '1);
    send_item(CMD_DRAW, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0);
    send_item(CMD_SEED, '0, '0);
    send_item(CMD_DRAW, '0, '0);
    send_item(CMD_SEED, '1, '1);
    repeat (4) send_item(CMD_DRAW, '1, '0);
    send_item(CMD_SEED, '0, 64'd1);
    repeat (2) send_item(CMD_DRAW, '0, '0);
    send_item(CMD_SEED, 64'h8000_0000_0000_0000, '0);
    repeat (2) send_item(CMD_DRAW, '0, '1);
    send_item(CMD_SEED, '0, '0);
    send_item(CMD_DRAW, '0, '0);
    drain_results();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain_results();
      pick = $urandom_range(99, 0);
      if (pick < 6) begin
        send_item(CMD_SEED, pick_word(), pick_word());
      end else if (pick < 8) begin
        send_item(CMD_SEED, '0, '0);
      end else begin
        send_item(CMD_DRAW, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("xorshift1024_star_wide_generator verification clean");
    end else begin
      $display("xorshift1024_star_wide_generator verification failed");
    end
    $finish;
  end

endmodule
